// ===== hdl/mh2_pkg.sv =====
// ---------------------------------------------------------------------------
// mh2_pkg
// Shared types, constants and the control store of the murmur2 hash unit.
// ---------------------------------------------------------------------------
`default_nettype none

package mh2_pkg;

   localparam logic [31:0] MIX_M = 32'h5bd1e995;
   localparam int unsigned MIX_R = 24;
   localparam int unsigned FIN_A = 13;
   localparam int unsigned FIN_B = 15;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CNT_W    = 3;
   localparam int unsigned STEP_W   = 3;
   localparam int unsigned CSR_AW   = 3;
   localparam logic [CNT_W-1:0] FULL_CNT = 3'd4;

   // csr register index
   localparam logic REG_HASH_SEED = 1'b0;

   // multiplier operand source
   typedef enum logic [2:0] {
      MUL_WORD,       // input word
      MUL_ACC_MIX,    // acc ^ (acc >> 24)
      MUL_HASH,       // running hash
      MUL_HASH_TAIL,  // running hash ^ masked tail bytes
      MUL_HASH_FIN    // running hash ^ (hash >> 13)
   } mul_sel_type;

   // branch condition
   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_IF_EMPTY,
      JMP_IF_PARTIAL,
      JMP_IF_OUT_BUSY
   } jmp_type;

   // end-of-transaction condition
   typedef enum logic [1:0] {
      FIN_NEVER,
      FIN_ALWAYS,
      FIN_IF_NOT_LAST
   } fin_type;

   typedef struct packed {
      mul_sel_type      mul_sel;
      logic             acc_we;
      logic             hash_we;
      logic             hash_fold;
      logic             pre;
      logic             emit;
      jmp_type          jmp;
      logic [STEP_W-1:0] target;
      fin_type          fin;
   } ctrl_word_type;

   // strobes from sequencer to datapath
   typedef struct packed {
      mul_sel_type mul_sel;
      logic        acc_we;
      logic        hash_we;
      logic        hash_fold;
      logic        pre;
      logic        emit;
      logic        load;
   } dp_ctrl_type;

   // datapath status used for branching
   typedef struct packed {
      logic empty;
      logic partial;
      logic last;
      logic out_busy;
   } dp_stat_type;

   localparam logic [STEP_W-1:0] ST_PRE  = 3'd0;
   localparam logic [STEP_W-1:0] ST_K1   = 3'd1;
   localparam logic [STEP_W-1:0] ST_K2   = 3'd2;
   localparam logic [STEP_W-1:0] ST_HF   = 3'd3;
   localparam logic [STEP_W-1:0] ST_TAIL = 3'd4;
   localparam logic [STEP_W-1:0] ST_AV1  = 3'd5;
   localparam logic [STEP_W-1:0] ST_AV2  = 3'd6;
   localparam logic [STEP_W-1:0] ST_CHK  = 3'd7;

   // control store
   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = '{mul_sel: MUL_WORD, acc_we: 1'b0, hash_we: 1'b0, hash_fold: 1'b0,
             pre: 1'b0, emit: 1'b0, jmp: JMP_NEXT, target: ST_PRE, fin: FIN_NEVER};
      unique case (step)
         ST_PRE: begin
            cw.pre    = 1'b1;
            cw.jmp    = JMP_IF_EMPTY;
            cw.target = ST_CHK;
         end
         ST_K1: begin
            cw.mul_sel = MUL_WORD;
            cw.acc_we  = 1'b1;
            cw.jmp     = JMP_IF_PARTIAL;
            cw.target  = ST_TAIL;
         end
         ST_K2: begin
            cw.mul_sel = MUL_ACC_MIX;
            cw.acc_we  = 1'b1;
         end
         ST_HF: begin
            cw.mul_sel   = MUL_HASH;
            cw.hash_we   = 1'b1;
            cw.hash_fold = 1'b1;
            cw.jmp       = JMP_ALWAYS;
            cw.target    = ST_AV1;
            cw.fin       = FIN_IF_NOT_LAST;
         end
         ST_TAIL: begin
            cw.mul_sel = MUL_HASH_TAIL;
            cw.hash_we = 1'b1;
            cw.fin     = FIN_IF_NOT_LAST;
         end
         ST_AV1: begin
            cw.mul_sel = MUL_HASH_FIN;
            cw.acc_we  = 1'b1;
         end
         ST_AV2: begin
            cw.emit   = 1'b1;
            cw.jmp    = JMP_IF_OUT_BUSY;
            cw.target = ST_AV2;
            cw.fin    = FIN_ALWAYS;
         end
         ST_CHK: begin
            cw.jmp    = JMP_ALWAYS;
            cw.target = ST_AV1;
            cw.fin    = FIN_IF_NOT_LAST;
         end
         default: begin
            cw.fin = FIN_ALWAYS;
         end
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/mh2_datapath.sv =====
// ---------------------------------------------------------------------------
// mh2_datapath
// Input holding registers, key state, one constant multiplier and the
// result register of the murmur2 hash unit.
// ---------------------------------------------------------------------------
`default_nettype none

module mh2_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mh2_pkg::dp_ctrl_type       ctrl,
   output mh2_pkg::dp_stat_type            stat,
   input  wire logic [31:0]                hash_seed,
   input  wire logic                       req_start_of_key,
   input  wire logic [31:0]                req_key_length,
   input  wire logic [31:0]                req_data_word,
   input  wire logic [mh2_pkg::CNT_W-1:0]  req_byte_count,
   input  wire logic                       req_end_of_key,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [31:0]                     rsp_hash_value,
   output logic                            rsp_length_error
);

   // transaction holding registers
   logic                        start_ff;
   logic [31:0]                 klen_ff;
   logic [31:0]                 word_ff;
   logic [mh2_pkg::CNT_W-1:0]   cnt_ff;
   logic                        last_ff;

   // key state
   logic [31:0] hash_ff, hash_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [31:0] len_ff, len_in;
   logic        misuse_ff, misuse_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_hash_ff;
   logic        out_err_ff;

   logic        over;
   logic [mh2_pkg::CNT_W-1:0] cnt_c;
   logic        partial;
   logic [31:0] tail;
   logic [31:0] mul_src;
   logic [31:0] mul_res;
   logic [31:0] bytes_base;
   logic [32:0] bytes_sum;
   logic        out_free;

   assign over    = cnt_ff > mh2_pkg::FULL_CNT;
   assign cnt_c   = over ? mh2_pkg::FULL_CNT : cnt_ff;
   assign partial = (cnt_c != '0) && (cnt_c != mh2_pkg::FULL_CNT);

   always_comb begin
      unique case (cnt_c)
         3'd1:    tail = {24'd0, word_ff[7:0]};
         3'd2:    tail = {16'd0, word_ff[15:0]};
         3'd3:    tail = {8'd0, word_ff[23:0]};
         default: tail = word_ff;
      endcase
   end

   always_comb begin
      unique case (ctrl.mul_sel)
         mh2_pkg::MUL_WORD:      mul_src = word_ff;
         mh2_pkg::MUL_ACC_MIX:   mul_src = acc_ff ^ (acc_ff >> mh2_pkg::MIX_R);
         mh2_pkg::MUL_HASH:      mul_src = hash_ff;
         mh2_pkg::MUL_HASH_TAIL: mul_src = hash_ff ^ tail;
         mh2_pkg::MUL_HASH_FIN:  mul_src = hash_ff ^ (hash_ff >> mh2_pkg::FIN_A);
         default:                mul_src = hash_ff;
      endcase
   end

   // low 32 bits of the product are all that is kept
   assign mul_res = mul_src * mh2_pkg::MIX_M;

   assign bytes_base = start_ff ? 32'd0 : bytes_ff;
   assign bytes_sum  = {1'b0, bytes_base} + {30'd0, cnt_c};
   assign out_free   = !out_valid_ff || !rsp_stall;

   always_comb begin
      hash_in   = hash_ff;
      acc_in    = acc_ff;
      bytes_in  = bytes_ff;
      len_in    = len_ff;
      misuse_in = misuse_ff;
      if (ctrl.pre) begin
         if (start_ff) begin
            hash_in = hash_seed ^ klen_ff;
            len_in  = klen_ff;
         end
         // byte total saturates
         bytes_in  = bytes_sum[32] ? 32'hffff_ffff : bytes_sum[31:0];
         misuse_in = (misuse_ff && !start_ff) || over || bytes_sum[32] ||
                     (partial && !last_ff);
      end
      if (ctrl.acc_we) begin
         acc_in = mul_res;
      end
      if (ctrl.hash_we) begin
         hash_in = ctrl.hash_fold ? (mul_res ^ acc_ff) : mul_res;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (ctrl.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         bytes_ff     <= '0;
         len_ff       <= '0;
         misuse_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         bytes_ff     <= bytes_in;
         len_ff       <= len_in;
         misuse_ff    <= misuse_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.load) begin
         start_ff <= req_start_of_key;
         klen_ff  <= req_key_length;
         word_ff  <= req_data_word;
         cnt_ff   <= req_byte_count;
         last_ff  <= req_end_of_key;
      end
      if (ctrl.emit) begin
         out_hash_ff <= acc_ff ^ (acc_ff >> mh2_pkg::FIN_B);
         out_err_ff  <= misuse_ff || (bytes_ff != len_ff);
      end
   end

   assign stat.empty    = (cnt_c == '0);
   assign stat.partial  = partial;
   assign stat.last     = last_ff;
   assign stat.out_busy = !out_free;

   assign rsp_valid        = out_valid_ff;
   assign rsp_hash_value   = out_hash_ff;
   assign rsp_length_error = out_err_ff;

endmodule

`default_nettype wire

// ===== hdl/mh2_sequencer.sv =====
// ---------------------------------------------------------------------------
// mh2_sequencer
// Step counter over the control store, with conditional jumps and the
// input handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module mh2_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire mh2_pkg::dp_stat_type  stat,
   output mh2_pkg::dp_ctrl_type       ctrl
);

   logic                        busy_ff, busy_in;
   logic [mh2_pkg::STEP_W-1:0]  step_ff, step_in;
   mh2_pkg::ctrl_word_type      cw;
   logic                        take;
   logic                        wait_out;
   logic                        fin;
   logic                        accept;

   assign cw = mh2_pkg::rom_word(step_ff);

   always_comb begin
      unique case (cw.jmp)
         mh2_pkg::JMP_NEXT:        take = 1'b0;
         mh2_pkg::JMP_ALWAYS:      take = 1'b1;
         mh2_pkg::JMP_IF_EMPTY:    take = stat.empty;
         mh2_pkg::JMP_IF_PARTIAL:  take = stat.partial;
         mh2_pkg::JMP_IF_OUT_BUSY: take = stat.out_busy;
         default:                  take = 1'b0;
      endcase
   end

   // result register still full: hold this step
   assign wait_out = (cw.jmp == mh2_pkg::JMP_IF_OUT_BUSY) && stat.out_busy;

   always_comb begin
      unique case (cw.fin)
         mh2_pkg::FIN_NEVER:       fin = 1'b0;
         mh2_pkg::FIN_ALWAYS:      fin = !wait_out;
         mh2_pkg::FIN_IF_NOT_LAST: fin = !stat.last;
         default:                  fin = 1'b1;
      endcase
   end

   // next transaction may enter on the final step
   assign req_stall = busy_ff && !fin;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = mh2_pkg::ST_PRE;
      end else if (busy_ff) begin
         if (fin) begin
            busy_in = 1'b0;
         end else if (take) begin
            step_in = cw.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= mh2_pkg::ST_PRE;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl.mul_sel   = cw.mul_sel;
   assign ctrl.acc_we    = busy_ff && cw.acc_we;
   assign ctrl.hash_we   = busy_ff && cw.hash_we;
   assign ctrl.hash_fold = cw.hash_fold;
   assign ctrl.pre       = busy_ff && cw.pre;
   assign ctrl.emit      = busy_ff && cw.emit && !wait_out;
   assign ctrl.load      = accept;

endmodule

`default_nettype wire

// ===== hdl/murmur2_hash32_unit.sv =====
// ---------------------------------------------------------------------------
// murmur2_hash32_unit
// 32-bit murmur2 key hash over a stream of little-endian words.
// ---------------------------------------------------------------------------
// One key word is taken per transaction and worked by a microcoded sequencer
// that steers a single 32x32 multiplier by the mixing constant. A full word
// that does not end the key takes three dependent multiplies and the length
// bookkeeping step; a partial one takes the bookkeeping, key and tail steps
// and an empty one the bookkeeping and check steps. The last word of a key
// adds the final avalanche and the result load, which waits while rsp_stall
// holds the result register. The next word is taken in the final step of the
// current one. The seed register is read at the first word of each key.
// ---------------------------------------------------------------------------
`default_nettype none

module murmur2_hash32_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // key words
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_start_of_key,
   input  wire logic [31:0]                 req_key_length,
   input  wire logic [31:0]                 req_data_word,
   input  wire logic [mh2_pkg::CNT_W-1:0]   req_byte_count,
   input  wire logic                        req_end_of_key,
   // hash results
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [31:0]                      rsp_hash_value,
   output logic                             rsp_length_error,
   // register access
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [mh2_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   logic [31:0]           seed_ff, seed_in;
   mh2_pkg::dp_ctrl_type  ctrl;
   mh2_pkg::dp_stat_type  stat;
   logic                  csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      seed_in = seed_ff;
      if (csr_wr && (paddr[2] == mh2_pkg::REG_HASH_SEED)) begin
         seed_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign prdata = (paddr[2] == mh2_pkg::REG_HASH_SEED) ? seed_ff : 32'd0;

   mh2_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   mh2_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .hash_seed        (seed_ff),
      .req_start_of_key (req_start_of_key),
      .req_key_length   (req_key_length),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_end_of_key   (req_end_of_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_length_error (rsp_length_error)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// murmur2_hash32_unit testbench
// Streams key words into the hash unit and checks every finished hash and
// its length flag against a cycle-free predictor kept inside the bench.
// A directed table covers the corner cases (empty key, tails, oversized and
// misplaced byte counts, length mismatch, keys that continue or are cut
// short), then random keys run under several seed settings with random
// gaps on the word side and random stalls on the result side.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned PHASE_WORDS   = 150;
   localparam int unsigned NUM_PHASES    = 5;
   localparam int unsigned NUM_ROWS      = 23;

   localparam logic [mh2_pkg::CSR_AW-1:0] SEED_ADDR = {mh2_pkg::REG_HASH_SEED, 2'b00};

   typedef struct packed {
      logic                       start;
      logic [31:0]                klen;
      logic [31:0]                word;
      logic [mh2_pkg::CNT_W-1:0]  cnt;
      logic                       last;
   } key_word_type;

   typedef struct packed {
      logic [31:0] hash;
      logic        length_error;
   } hash_result_type;

   // which parts of a directed row's result are typed in the table
   typedef enum logic [1:0] {
      KNOWN_NONE = 2'b00,
      KNOWN_FLAG = 2'b01,
      KNOWN_ALL  = 2'b11
   } typed_check_type;

   typedef struct packed {
      key_word_type    w;
      typed_check_type known;
      logic [31:0]     hash;
      logic            length_error;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // no start mark right after reset: 4 bytes against a stated length of 0
      '{'{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 3'd4, 1'b1}, KNOWN_FLAG, 32'h0, 1'b1},
      // empty key under a zero seed hashes to zero, unused bytes ignored
      '{'{1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 1'b1}, KNOWN_ALL,  32'h0, 1'b0},
      '{'{1'b1, 32'h0000_0004, 32'hFFFF_FFFF, 3'd4, 1'b1}, KNOWN_FLAG, 32'h0, 1'b0},
      '{'{1'b1, 32'h0000_0004, 32'h0000_0000, 3'd4, 1'b1}, KNOWN_FLAG, 32'h0, 1'b0},
      '{'{1'b1, 32'h0000_0001, 32'hFFFF_FF5A, 3'd1, 1'b1}, KNOWN_FLAG, 32'h0, 1'b0},
      '{'{1'b1, 32'h0000_0002, 32'hFFFF_C33C, 3'd2, 1'b1}, KNOWN_FLAG, 32'h0, 1'b0},
      '{'{1'b1, 32'h0000_0003, 32'hFF12_3456, 3'd3, 1'b1}, KNOWN_FLAG, 32'h0, 1'b0},
      // two words, key_length on the second word is ignored
      '{'{1'b1, 32'h0000_0007, 32'h89AB_CDEF, 3'd4, 1'b0}, KNOWN_NONE, 32'h0, 1'b0},
      '{'{1'b0, 32'hFFFF_FFFF, 32'h0055_AA11, 3'd3, 1'b1}, KNOWN_FLAG, 32'h0, 1'b0},
      // byte count above four
      '{'{1'b1, 32'h0000_0004, 32'h1234_5678, 3'd7, 1'b1}, KNOWN_FLAG, 32'h0, 1'b1},
      '{'{1'b1, 32'h0000_0008, 32'hDEAD_BEEF, 3'd5, 1'b0}, KNOWN_NONE, 32'h0, 1'b0},
      '{'{1'b0, 32'h0000_0000, 32'hCAFE_F00D, 3'd6, 1'b1}, KNOWN_FLAG, 32'h0, 1'b1},
      // partial word that is not last
      '{'{1'b1, 32'h0000_0006, 32'h0000_7E81, 3'd2, 1'b0}, KNOWN_NONE, 32'h0, 1'b0},
      '{'{1'b0, 32'h0000_0000, 32'h8000_0001, 3'd4, 1'b1}, KNOWN_FLAG, 32'h0, 1'b1},
      // stated length disagrees, then the ended key is continued
      '{'{1'b1, 32'h0000_0009, 32'h0F0F_0F0F, 3'd4, 1'b1}, KNOWN_FLAG, 32'h0, 1'b1},
      '{'{1'b0, 32'hFFFF_FFFF, 32'hF0F0_F0F0, 3'd4, 1'b1}, KNOWN_FLAG, 32'h0, 1'b1},
      // zero-count word inside a key
      '{'{1'b1, 32'h0000_0004, 32'hFFFF_FFFF, 3'd0, 1'b0}, KNOWN_NONE, 32'h0, 1'b0},
      '{'{1'b0, 32'h0000_0000, 32'h7654_3210, 3'd4, 1'b1}, KNOWN_FLAG, 32'h0, 1'b0},
      '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b1}, KNOWN_FLAG, 32'h0, 1'b1},
      // key cut short by a new start mark
      '{'{1'b1, 32'h0000_000C, 32'h1111_2222, 3'd4, 1'b0}, KNOWN_NONE, 32'h0, 1'b0},
      '{'{1'b1, 32'h0000_0005, 32'h3333_4444, 3'd4, 1'b0}, KNOWN_NONE, 32'h0, 1'b0},
      '{'{1'b0, 32'h0000_0000, 32'hFFFF_FF00, 3'd1, 1'b1}, KNOWN_FLAG, 32'h0, 1'b0},
      // empty key that claims bytes
      '{'{1'b1, 32'h0000_0003, 32'h0000_0000, 3'd0, 1'b1}, KNOWN_FLAG, 32'h0, 1'b1}
   };

   logic                       clock;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic                       req_start_of_key = 1'b0;
   logic [31:0]                req_key_length   = '0;
   logic [31:0]                req_data_word    = '0;
   logic [mh2_pkg::CNT_W-1:0]  req_byte_count   = '0;
   logic                       req_end_of_key   = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic [31:0]                rsp_hash_value;
   logic                       rsp_length_error;
   logic                       psel             = 1'b0;
   logic                       penable          = 1'b0;
   logic                       pwrite           = 1'b0;
   logic [mh2_pkg::CSR_AW-1:0] paddr            = '0;
   logic [31:0]                pwdata           = '0;
   logic [31:0]                prdata;
   logic                       pready;

   // predictor state
   logic [31:0] seed_shadow = '0;
   logic [31:0] acc_hash    = '0;
   logic [31:0] acc_bytes   = '0;
   logic [31:0] acc_length  = '0;
   logic        acc_misuse  = 1'b0;

   hash_result_type pending_hashes [$];
   int unsigned  failures    = 0;
   int unsigned  idle_cycles = 0;
   bit           req_quiet   = 1'b0;
   bit           rsp_quiet   = 1'b0;
   int unsigned  rsp_hold    = 0;

   murmur2_hash32_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_of_key (req_start_of_key),
      .req_key_length   (req_key_length),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_end_of_key   (req_end_of_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_length_error (rsp_length_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] mix_mul(input logic [31:0] a);
      return a * mh2_pkg::MIX_M;
   endfunction

   // folds one key word into the running state, returns 1 when a hash is due
   function automatic bit absorb_key_word(input key_word_type w, output hash_result_type r);
      logic [mh2_pkg::CNT_W-1:0] n;
      logic [31:0]      k;
      logic [31:0]      h;
      logic [32:0]      total;
      n = w.cnt;
      r = '0;
      if (w.start) begin
         acc_hash   = seed_shadow ^ w.klen;
         acc_bytes  = '0;
         acc_length = w.klen;
         acc_misuse = 1'b0;
      end
      if (n > mh2_pkg::FULL_CNT) begin
         n = mh2_pkg::FULL_CNT;
         acc_misuse = 1'b1;
      end
      if (n == mh2_pkg::FULL_CNT) begin
         k = mix_mul(w.word);
         k = k ^ (k >> mh2_pkg::MIX_R);
         k = mix_mul(k);
         acc_hash = mix_mul(acc_hash) ^ k;
      end else if (n != '0) begin
         acc_hash = mix_mul(acc_hash ^ (w.word & ~(32'hFFFF_FFFF << (8 * n))));
         if (!w.last) acc_misuse = 1'b1;
      end
      // byte total saturates instead of wrapping
      total = {1'b0, acc_bytes} + 33'(n);
      if (total[32]) begin
         acc_bytes  = '1;
         acc_misuse = 1'b1;
      end else begin
         acc_bytes = total[31:0];
      end
      if (!w.last) return 1'b0;
      h = acc_hash;
      h = h ^ (h >> mh2_pkg::FIN_A);
      h = mix_mul(h);
      h = h ^ (h >> mh2_pkg::FIN_B);
      r.hash         = h;
      r.length_error = acc_misuse || (acc_bytes != acc_length);
      return 1'b1;
   endfunction

   task automatic send_word(input key_word_type w, input typed_check_type known,
                            input logic [31:0] typed_hash, input logic typed_err);
      int unsigned     gap;
      hash_result_type r;
      if ($urandom_range(0, 31) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_start_of_key <= w.start;
      req_key_length   <= w.klen;
      req_data_word    <= w.word;
      req_byte_count   <= w.cnt;
      req_end_of_key   <= w.last;
      do @(posedge clock); while (req_stall);
      if (absorb_key_word(w, r)) begin
         if (known == KNOWN_ALL) r.hash = typed_hash;
         if (known != KNOWN_NONE) r.length_error = typed_err;
         pending_hashes.push_back(r);
      end
   endtask

   // drains results, then lets a word without an end mark finish inside the block
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_xfer(input logic wr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= SEED_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic seed_readback(input logic [31:0] want);
      logic [31:0] got;
      csr_xfer(1'b0, '0, got);
      if (got !== want) begin
         $error("hash_seed readback: expected %h, got %h", want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      hash_result_type want;
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_hashes.size() == 0) begin
               $error("unexpected result transaction: hash_value %h length_error %b",
                      rsp_hash_value, rsp_length_error);
               failures++;
            end else begin
               want = pending_hashes.pop_front();
               if (rsp_hash_value !== want.hash) begin
                  $error("hash_value: expected %h, got %h", want.hash, rsp_hash_value);
                  failures++;
               end
               if (rsp_length_error !== want.length_error) begin
                  $error("length_error: expected %b, got %b",
                         want.length_error, rsp_length_error);
                  failures++;
               end
            end
            if ($urandom_range(0, 31) == 0) rsp_quiet = !rsp_quiet;
            rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 12);
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      key_word_type w;
      logic [31:0] seeds [NUM_PHASES];
      logic [31:0] dummy;
      logic [31:0] stated;
      int unsigned sent;
      int unsigned pick;
      int          left;
      int          idx;
      int          bad_at;
      bit          first;

      seeds = '{32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom, 32'h0000_0000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      seed_readback(32'h0000_0000);

      foreach (DIRECTED_ROWS[i])
         send_word(DIRECTED_ROWS[i].w, DIRECTED_ROWS[i].known,
                   DIRECTED_ROWS[i].hash, DIRECTED_ROWS[i].length_error);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         csr_xfer(1'b1, seeds[p], dummy);
         seed_shadow = seeds[p];
         seed_readback(seeds[p]);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               // noise: any field combination
               w.start = $urandom_range(0, 1);
               w.klen  = $urandom;
               w.word  = $urandom;
               w.cnt   = $urandom_range(0, 7);
               w.last  = $urandom_range(0, 1);
               send_word(w, KNOWN_NONE, '0, 1'b0);
               sent++;
            end else begin
               left   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                    : $urandom_range(0, 16);
               stated = left;
               bad_at = -1;
               if (pick < 18) stated = $urandom;
               else if (pick < 24) bad_at = $urandom_range(0, left / 4);
               first = 1'b1;
               idx   = 0;
               do begin
                  w.start = first;
                  w.klen  = first ? stated : $urandom;
                  w.word  = $urandom;
                  w.cnt   = (left >= 4) ? mh2_pkg::FULL_CNT : mh2_pkg::CNT_W'(left);
                  if (left != 0 && $urandom_range(0, 19) == 0) w.cnt = '0;
                  left   -= w.cnt;
                  w.last  = (left == 0);
                  if (idx == bad_at) w.cnt = $urandom_range(5, 7);
                  send_word(w, KNOWN_NONE, '0, 1'b0);
                  sent++;
                  first = 1'b0;
                  idx++;
               end while (left != 0);
            end
         end
      end

      wait_idle();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== murmur2_hash32_unit.f =====
hdl/mh2_pkg.sv
hdl/mh2_datapath.sv
hdl/mh2_sequencer.sv
hdl/murmur2_hash32_unit.sv
sim/testbench.sv
